/* rtl/mau_pkg.sv */
// shared widths, operation codes and tag type for the modular arithmetic unit
package mau_pkg;

	localparam int DATA_WIDTH = 31;
	localparam int OP_WIDTH = 3;

	localparam logic [OP_WIDTH-1:0] OP_REDUCE = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_ADD    = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_SUB    = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_MUL    = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_NEG    = 3'd4;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic                valid;
		logic [OP_WIDTH-1:0] op;
	} tag_t;

	// x + y reduced once against m, x and y below m
	function automatic word_t add_mod(word_t x, word_t y, word_t m);
		logic [DATA_WIDTH:0] s;
		logic [DATA_WIDTH:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, m};
		add_mod = (s >= {1'b0, m}) ? d[DATA_WIDTH-1:0] : s[DATA_WIDTH-1:0];
	endfunction

endpackage

/* rtl/mau_reduce.sv */
// restoring remainder pipeline: both operands reduced mod m, one bit per stage
module mau_reduce (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  mau_pkg::word_t modulus,
	input  mau_pkg::tag_t  tag_in,
	input  mau_pkg::word_t a_in,
	input  mau_pkg::word_t b_in,
	output mau_pkg::tag_t  tag_out,
	output mau_pkg::word_t a_out,
	output mau_pkg::word_t b_out
);
	import mau_pkg::*;

	tag_t  tag_s [0:DATA_WIDTH];
	word_t xa_s  [0:DATA_WIDTH];
	word_t xb_s  [0:DATA_WIDTH];
	word_t ra_s  [0:DATA_WIDTH];
	word_t rb_s  [0:DATA_WIDTH];

	assign tag_s[0] = tag_in;
	assign xa_s[0]  = a_in;
	assign xb_s[0]  = b_in;
	assign ra_s[0]  = '0;
	assign rb_s[0]  = '0;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		logic [DATA_WIDTH:0] sa, sb, da, db;
		always_comb begin
			sa = {ra_s[i], xa_s[i][DATA_WIDTH-1-i]};
			sb = {rb_s[i], xb_s[i][DATA_WIDTH-1-i]};
			da = sa - {1'b0, modulus};
			db = sb - {1'b0, modulus};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (advance) begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				xa_s[i+1] <= xa_s[i];
				xb_s[i+1] <= xb_s[i];
				ra_s[i+1] <= (sa >= {1'b0, modulus}) ? da[DATA_WIDTH-1:0] : sa[DATA_WIDTH-1:0];
				rb_s[i+1] <= (sb >= {1'b0, modulus}) ? db[DATA_WIDTH-1:0] : sb[DATA_WIDTH-1:0];
			end
		end
	end

	assign tag_out = tag_s[DATA_WIDTH];
	assign a_out   = ra_s[DATA_WIDTH];
	assign b_out   = rb_s[DATA_WIDTH];

endmodule

/* rtl/mau_modmul.sv */
// shift-and-add modular product, one doubling or one conditional add per stage
module mau_modmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  mau_pkg::word_t modulus,
	input  mau_pkg::tag_t  tag_in,
	input  mau_pkg::word_t a_in,
	input  mau_pkg::word_t b_in,
	output mau_pkg::tag_t  tag_out,
	output mau_pkg::word_t a_out,
	output mau_pkg::word_t b_out,
	output mau_pkg::word_t prod_out
);
	import mau_pkg::*;

	localparam int STEPS = 2 * DATA_WIDTH;

	tag_t  tag_s [0:STEPS];
	word_t a_s   [0:STEPS];
	word_t b_s   [0:STEPS];
	word_t p_s   [0:STEPS];

	assign tag_s[0] = tag_in;
	assign a_s[0]   = a_in;
	assign b_s[0]   = b_in;
	assign p_s[0]   = '0;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		word_t p_next;
		always_comb begin
			if (j % 2 == 0) begin
				p_next = add_mod(p_s[j], p_s[j], modulus);
			end else if (b_s[j][DATA_WIDTH-1-j/2]) begin
				p_next = add_mod(p_s[j], a_s[j], modulus);
			end else begin
				p_next = p_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j+1] <= '0;
			end else if (advance) begin
				tag_s[j+1] <= tag_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				a_s[j+1] <= a_s[j];
				b_s[j+1] <= b_s[j];
				p_s[j+1] <= p_next;
			end
		end
	end

	assign tag_out  = tag_s[STEPS];
	assign a_out    = a_s[STEPS];
	assign b_out    = b_s[STEPS];
	assign prod_out = p_s[STEPS];

endmodule

/* rtl/modular_arithmetic_unit_core.sv */
// top level: modulus register, reduce and multiply pipelines, result select
//
// channel | signals                            | dir
// input   | in_valid in_stall op operand_a/_b  | in
// output  | out_valid out_stall result         | out
// config  | cfg_we cfg_wdata                   | in
//
// one beat enters per cycle unless in_stall is high; the delay is set by the
// bit-per-stage remainder pipeline and the two-steps-per-bit product pipeline.
// reset clears the valid bits and sets the modulus to 1.
// a stalled output beat freezes the whole pipeline, so in_stall follows it.
module modular_arithmetic_unit_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mau_pkg::OP_WIDTH-1:0] op,
	input  mau_pkg::word_t            operand_a,
	input  mau_pkg::word_t            operand_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output mau_pkg::word_t            result,
	input  logic                      cfg_we,
	input  mau_pkg::word_t            cfg_wdata
);
	import mau_pkg::*;

	word_t modulus_q;
	logic  advance;
	tag_t  tag_in, tag_r, tag_m;
	word_t a_r, b_r, a_m, b_m, p_m;
	word_t res_next;
	logic  out_valid_q;
	word_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= word_t'(1);
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;
	assign tag_in   = '{valid: in_valid, op: op};

	mau_reduce u_reduce (
		.clk(clk), .arst_n(arst_n), .advance(advance), .modulus(modulus_q),
		.tag_in(tag_in), .a_in(operand_a), .b_in(operand_b),
		.tag_out(tag_r), .a_out(a_r), .b_out(b_r)
	);

	mau_modmul u_modmul (
		.clk(clk), .arst_n(arst_n), .advance(advance), .modulus(modulus_q),
		.tag_in(tag_r), .a_in(a_r), .b_in(b_r),
		.tag_out(tag_m), .a_out(a_m), .b_out(b_m), .prod_out(p_m)
	);

	always_comb begin
		logic [DATA_WIDTH:0] diff;
		diff = {1'b0, a_m} - {1'b0, b_m};
		case (tag_m.op)
			OP_REDUCE: res_next = a_m;
			OP_ADD:    res_next = add_mod(a_m, b_m, modulus_q);
			// borrow means b > a, wrap by adding m
			OP_SUB:    res_next = diff[DATA_WIDTH] ? diff[DATA_WIDTH-1:0] + modulus_q
			                                       : diff[DATA_WIDTH-1:0];
			OP_MUL:    res_next = p_m;
			OP_NEG:    res_next = (a_m == '0) ? '0 : modulus_q - a_m;
			default:   res_next = '0;
		endcase
		if (modulus_q == '0) begin
			res_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tag_m.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

`ifndef SYNTHESIS
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus_q != '0 |-> result < modulus_q)
		else $error("result not below modulus");
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus_q == '0 |-> result == '0)
		else $error("nonzero result with zero modulus");
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output beat");
`endif

endmodule

/* tb/modular_arithmetic_unit_checker.sv */
// checker for the modular arithmetic unit: predicts residues and compares result beats
`timescale 1ns / 1ps
module modular_arithmetic_unit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [mau_pkg::OP_WIDTH-1:0]  op,
	input  mau_pkg::word_t                operand_a,
	input  mau_pkg::word_t                operand_b,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  mau_pkg::word_t                result,
	input  logic                          cfg_we,
	input  mau_pkg::word_t                cfg_wdata,
	output int                            fail_count,
	output int                            pending,
	output logic                          activity
);
	import mau_pkg::*;

	word_t modulus_q;
	word_t residue_q[$];

	function automatic word_t residue_of(logic [OP_WIDTH-1:0] code, word_t a, word_t b,
		word_t m);
		logic [2*DATA_WIDTH-1:0] prod;
		logic [DATA_WIDTH:0] s;
		word_t ar;
		word_t br;
		if (m == 0)
			return '0;
		ar = a % m;
		br = b % m;
		case (code)
			OP_REDUCE: return ar;
			OP_ADD: begin
				s = ar + br;
				if (s >= m)
					s = s - m;
				return s[DATA_WIDTH-1:0];
			end
			OP_SUB: return (br > ar) ? word_t'(ar + (m - br)) : word_t'(ar - br);
			OP_MUL: begin
				prod = ar * {{DATA_WIDTH{1'b0}}, br};
				return word_t'(prod % m);
			end
			OP_NEG: return (ar == 0) ? word_t'(0) : word_t'(m - ar);
			default: return '0;
		endcase
	endfunction

	assign pending = residue_q.size();
	assign activity = (in_valid && !in_stall) || (out_valid && !out_stall);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 1;
			fail_count <= 0;
			residue_q.delete();
		end else begin
			if (cfg_we)
				modulus_q <= cfg_wdata;
			if (in_valid && !in_stall)
				residue_q.push_back(residue_of(op, operand_a, operand_b, modulus_q));
			if (out_valid && !out_stall) begin
				if (residue_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %0d", result);
					fail_count <= fail_count + 1;
				end else begin
					if (result !== residue_q[0]) begin
						if (fail_count < 10)
							$display("result mismatch: expected %0d actual %0d",
								residue_q[0], result);
						fail_count <= fail_count + 1;
					end
					void'(residue_q.pop_front());
				end
			end
		end
	end
endmodule

/* tb/modular_arithmetic_unit_core_tb.sv */
// testbench top for the modular arithmetic unit: stimulus, stalls and verdict
`timescale 1ns / 1ps
module modular_arithmetic_unit_core_tb;
	import mau_pkg::*;

	localparam int LATENCY = 3 * DATA_WIDTH + 1;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [OP_WIDTH-1:0] op = '0;
	word_t operand_a = '0;
	word_t operand_b = '0;
	logic out_valid;
	logic out_stall = 0;
	word_t result;
	logic cfg_we = 0;
	word_t cfg_wdata = '0;
	int fail_count;
	int pending;
	logic activity;
	bit calm = 0;
	bit hold_off = 0;
	word_t modulus_now = 1;
	int idle_cycles = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	modular_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	modular_arithmetic_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.operand_a(operand_a), .operand_b(operand_b), .out_valid(out_valid),
		.out_stall(out_stall), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending), .activity(activity)
	);

	// receiver stalls at random, except in calm stretches or during a hold-off
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1;
		else if (calm)
			out_stall <= 0;
		else
			out_stall <= ($urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if (activity || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic word_t residue_pick(word_t m);
		case ($urandom_range(5))
			0: return 0;
			1: return (m == 0) ? word_t'(0) : word_t'(m - 1);
			2: return word_t'($urandom);
			default: return (m == 0) ? word_t'(0) : word_t'($urandom % m);
		endcase
	endfunction

	// in_valid stays high after a beat; the next idle gap or end_beats drops it
	task automatic send_beat(logic [OP_WIDTH-1:0] code, word_t a, word_t b);
		if (!calm)
			while ($urandom_range(99) < 27) begin
				in_valid <= 0;
				@(posedge clk);
			end
		in_valid <= 1;
		op <= code;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic end_beats();
		in_valid <= 0;
	endtask

	task automatic set_modulus(word_t m);
		end_beats();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 0;
		modulus_now = m;
	endtask

	task automatic random_beats(int count);
		logic [OP_WIDTH-1:0] code;
		for (int i = 0; i < count; i++) begin
			code = ($urandom_range(19) == 0) ? OP_WIDTH'($urandom_range(7, 5))
				: OP_WIDTH'($urandom_range(4));
			send_beat(code, (code == OP_REDUCE || $urandom_range(9) == 0)
				? word_t'($urandom) : residue_pick(modulus_now), residue_pick(modulus_now));
		end
	endtask

	initial begin
		word_t moduli[6];
		moduli = '{word_t'(7), word_t'(2147483647), word_t'(2), word_t'(1000003),
			word_t'($urandom_range(2147483647, 1)), word_t'(0)};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset modulus of one: everything reduces to zero
		send_beat(OP_MUL, word_t'(2147483647), word_t'(2147483647));
		set_modulus(word_t'(2147483647));
		calm = 1;
		send_beat(OP_REDUCE, word_t'(2147483647), 0);
		send_beat(OP_REDUCE, word_t'(2147483646), 0);
		send_beat(OP_ADD, word_t'(2147483646), word_t'(2147483646));
		send_beat(OP_ADD, 0, 0);
		send_beat(OP_SUB, 0, word_t'(2147483646));
		send_beat(OP_SUB, 5, 5);
		send_beat(OP_MUL, word_t'(2147483646), word_t'(2147483646));
		send_beat(OP_MUL, word_t'(1234567), 0);
		send_beat(OP_NEG, 0, 0);
		send_beat(OP_NEG, 1, 0);
		send_beat(OP_NEG, word_t'(2147483647), 0);
		send_beat(3'd5, 9, 9);
		send_beat(3'd6, 9, 9);
		send_beat(3'd7, 9, 9);
		send_beat(OP_ADD, word_t'(2147483647), word_t'(2147483647));
		calm = 0;
		// long hold-off so the pipeline fills and stalls its input
		fork
			begin
				hold_off = 1;
				repeat (3 * LATENCY) @(posedge clk);
				hold_off = 0;
			end
			random_beats(150);
		join
		foreach (moduli[k]) begin
			set_modulus(moduli[k]);
			if (k == 2)
				calm = 1;
			random_beats(k == 5 ? 20 : 100);
			calm = 0;
		end
		set_modulus(word_t'($urandom_range(65535, 3)));
		random_beats(60);
		end_beats();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

/* modular_arithmetic_unit_core.f */
rtl/mau_pkg.sv
rtl/mau_reduce.sv
rtl/mau_modmul.sv
rtl/modular_arithmetic_unit_core.sv
tb/modular_arithmetic_unit_checker.sv
tb/modular_arithmetic_unit_core_tb.sv
